[hdl/occupancy_light_controller_top_defines.svh]
// Assertion macros shared by the occupancy light controller RTL.
// Needs signals named clock and reset in the scope of each use.
`ifndef OCCUPANCY_LIGHT_CONTROLLER_TOP_DEFINES_SVH
`define OCCUPANCY_LIGHT_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OLC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define OLC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/olc_pkg.sv]
`timescale 1ns / 1ps
// Types and constants for the occupancy light controller.
// No dependencies; used by olc_csr, olc_core, the top level and the bench.
package olc_pkg;

   localparam int unsigned THRESH_W  = 13;
   localparam int unsigned AMBIENT_W = 12;
   localparam int unsigned TICKS_W   = 24;

   // half width of the hysteresis band around the threshold
   localparam logic [THRESH_W-1:0] AMB_BAND = 13'd100;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 13'd2048;
   localparam logic [TICKS_W-1:0]  OFF_DELAY_RESET = 24'd5000;
   localparam logic [TICKS_W-1:0]  MOTION_HOLD_RESET = 24'd2000;

   typedef enum logic [1:0] {
      CSR_MANUAL_OVERRIDE   = 2'd0,
      CSR_AMBIENT_THRESHOLD = 2'd1,
      CSR_OFF_DELAY_TICKS   = 2'd2,
      CSR_MOTION_HOLD_TICKS = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                 cmd;
      logic                 pir_level;
      logic [AMBIENT_W-1:0] ambient_level;
      logic                 manual_on;
   } req_type;

   typedef struct packed {
      logic light_on;
      logic light_changed;
      logic motion_recent;
      logic motion_changed;
   } rsp_type;

   typedef struct packed {
      csr_index_type      index;
      logic [TICKS_W-1:0] data;
   } csr_type;

   typedef struct packed {
      logic                manual_override;
      logic [THRESH_W-1:0] ambient_threshold;
      logic [TICKS_W-1:0]  off_delay_ticks;
      logic [TICKS_W-1:0]  motion_hold_ticks;
   } cfg_type;

endpackage

[hdl/olc_chan_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload item per handshake.
// Payload types come from olc_pkg at the point of instantiation.
interface olc_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hdl/olc_csr.sv]
`timescale 1ns / 1ps
// Configuration register file of the occupancy light controller.
// Depends on olc_pkg and olc_chan_if.
module olc_csr (
   input  logic                clock,
   input  logic                reset,
   olc_chan_if.sink            csr_chan,
   output olc_pkg::cfg_type    cfg
);

   olc_pkg::cfg_type cfg_ff;
   olc_pkg::cfg_type cfg_in;
   logic             wr_fire;

   assign csr_chan.ready = 1'b1;
   assign wr_fire = csr_chan.valid;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         unique case (csr_chan.payload.index)
            olc_pkg::CSR_MANUAL_OVERRIDE:
               cfg_in.manual_override = csr_chan.payload.data[0];
            olc_pkg::CSR_AMBIENT_THRESHOLD:
               cfg_in.ambient_threshold = csr_chan.payload.data[olc_pkg::THRESH_W-1:0];
            olc_pkg::CSR_OFF_DELAY_TICKS:
               cfg_in.off_delay_ticks = csr_chan.payload.data;
            olc_pkg::CSR_MOTION_HOLD_TICKS:
               cfg_in.motion_hold_ticks = csr_chan.payload.data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.manual_override   <= 1'b0;
         cfg_ff.ambient_threshold <= olc_pkg::THRESH_RESET;
         cfg_ff.off_delay_ticks   <= olc_pkg::OFF_DELAY_RESET;
         cfg_ff.motion_hold_ticks <= olc_pkg::MOTION_HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hdl/olc_core.sv]
`timescale 1ns / 1ps
// Motion flag, hysteresis light decision and the two saturating age counters.
// Depends on olc_pkg and the assertion macro header.
`include "occupancy_light_controller_top_defines.svh"
module olc_core #(
   parameter int unsigned AGE_WIDTH = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  olc_pkg::req_type item,
   input  olc_pkg::cfg_type cfg,
   output olc_pkg::rsp_type result
);

   localparam int unsigned CMP_W =
      (AGE_WIDTH > olc_pkg::TICKS_W) ? AGE_WIDTH : olc_pkg::TICKS_W;
   localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

   logic                 motion_flag_ff, motion_flag_in;
   logic [AGE_WIDTH-1:0] motion_age_ff, motion_age_in;
   logic                 light_ff, light_in;
   logic [AGE_WIDTH-1:0] light_age_ff, light_age_in;

   logic [olc_pkg::THRESH_W:0]   band_hi;
   logic [olc_pkg::THRESH_W-1:0] band_lo;

   // band edges; the low edge stops at zero
   assign band_hi = (olc_pkg::THRESH_W+1)'(cfg.ambient_threshold)
                  + (olc_pkg::THRESH_W+1)'(olc_pkg::AMB_BAND);
   assign band_lo = (cfg.ambient_threshold >= olc_pkg::AMB_BAND)
                  ? cfg.ambient_threshold - olc_pkg::AMB_BAND : '0;

   always_comb begin
      motion_flag_in = motion_flag_ff;
      motion_age_in  = motion_age_ff;
      light_in       = light_ff;
      light_age_in   = light_age_ff;
      if (item.cmd) begin
         // manual command: time stands still
         if (cfg.manual_override) begin
            light_in = item.manual_on;
         end
      end else begin
         if (item.pir_level) begin
            motion_flag_in = 1'b1;
            motion_age_in  = '0;
         end else if (motion_age_ff != AGE_MAX) begin
            motion_age_in = motion_age_ff + 1'b1;
         end
         if (CMP_W'(motion_age_in) > CMP_W'(cfg.motion_hold_ticks)) begin
            motion_flag_in = 1'b0;
         end

         if (light_age_ff != AGE_MAX) begin
            light_age_in = light_age_ff + 1'b1;
         end

         if (!cfg.manual_override) begin
            if (motion_flag_in) begin
               // inside the band the light keeps its state
               if ((olc_pkg::THRESH_W+1)'(item.ambient_level) > band_hi) begin
                  light_in = 1'b0;
               end else if (olc_pkg::THRESH_W'(item.ambient_level) < band_lo) begin
                  light_in = 1'b1;
               end
            end
            if (light_in && motion_flag_in) begin
               light_age_in = '0;
            end
            if (light_in && (CMP_W'(light_age_in) > CMP_W'(cfg.off_delay_ticks))) begin
               light_in = 1'b0;
            end
         end
      end
   end

   assign result.light_on       = light_in;
   assign result.light_changed  = light_in ^ light_ff;
   assign result.motion_recent  = motion_flag_in;
   assign result.motion_changed = motion_flag_in ^ motion_flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_flag_ff <= 1'b0;
         motion_age_ff  <= '0;
         light_ff       <= 1'b0;
         light_age_ff   <= '0;
      end else if (advance) begin
         motion_flag_ff <= motion_flag_in;
         motion_age_ff  <= motion_age_in;
         light_ff       <= light_in;
         light_age_ff   <= light_age_in;
      end
   end

   // commands never touch the motion state
   `OLC_ASSERT_NEXT(a_cmd_keeps_motion, advance && item.cmd,
      motion_flag_ff == $past(motion_flag_ff) && motion_age_ff == $past(motion_age_ff),
      "command item changed motion state")
   // a PIR hit always leaves the flag set with a fresh age
   `OLC_ASSERT_NEXT(a_pir_sets_flag, advance && !item.cmd && item.pir_level,
      motion_flag_ff && motion_age_ff == '0, "PIR hit did not set motion flag")
   // in override mode, ticks leave the light alone
   `OLC_ASSERT_NEXT(a_override_tick_holds_light,
      advance && !item.cmd && cfg.manual_override,
      light_ff == $past(light_ff), "tick changed light under manual override")
   // change flags agree with the stored state whenever an item is taken
   `OLC_ASSERT_NOW(a_changed_flags, advance,
      result.light_changed == (result.light_on != light_ff)
      && result.motion_changed == (result.motion_recent != motion_flag_ff),
      "change flag disagrees with state")

endmodule

[hdl/occupancy_light_controller_top.sv]
`timescale 1ns / 1ps
// Top level of the occupancy light controller: input register, core, result register.
// Depends on olc_pkg, olc_chan_if, olc_csr and olc_core.
//
// Use:
//   req_chan  - one item per handshake: a 1 ms tick (cmd = 0) carrying the PIR level
//               and a 12-bit ambient sample, or a manual light command (cmd = 1).
//   rsp_chan  - exactly one result item per request item, in order: light state,
//               motion flag and whether either changed on that item.
//   csr_chan  - register writes (index 0..3), always ready; write only while no
//               item is in flight.
// Path: an accepted request waits in the input register until the result register is
//   free, then moves on (two registers: input register, result register).
// Throughput: one item per clock while rsp_chan is ready. All per-item work is a short
//   compare and saturating-increment path between the input and result registers.
// Stall: when rsp_chan is not ready the result register holds; the input
//   register still takes one more item, after which req_chan.ready drops.
// Reset (synchronous): light off, motion flag clear, both ages zero, registers to
//   defaults (override off, threshold 2048, off delay 5000, hold 2000), both
//   channel registers emptied.
module occupancy_light_controller_top #(
   parameter int unsigned AGE_WIDTH = 24
) (
   input  logic       clock,
   input  logic       reset,
   olc_chan_if.sink   req_chan,
   olc_chan_if.source rsp_chan,
   olc_chan_if.sink   csr_chan
);

   // input register
   logic             in_valid_ff, in_valid_in;
   olc_pkg::req_type in_item_ff, in_item_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   olc_pkg::rsp_type rsp_item_ff, rsp_item_in;

   olc_pkg::cfg_type cfg;
   olc_pkg::rsp_type core_result;

   logic req_fire;
   logic rsp_fire;
   logic advance;    // item moves from input register into the result register

   olc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   olc_core #(
      .AGE_WIDTH (AGE_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   assign rsp_fire = rsp_valid_ff && rsp_chan.ready;
   // result slot is free if empty or being emptied this cycle
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_item_in  = req_chan.payload;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = core_result;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_item_ff  <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_item_ff;

endmodule

[sim/occupancy_light_controller_top_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for occupancy_light_controller_top: random and directed items,
// each result predicted here. Needs olc_pkg, olc_chan_if and the block's RTL.
module occupancy_light_controller_top_test;

   localparam int unsigned AGE_W     = 24;
   localparam int unsigned RUN_LIMIT = 150000;   // cycles; a correct run needs far fewer

   logic clock = 1'b0;
   logic reset;

   olc_chan_if #(.payload_type(olc_pkg::req_type)) req_if ();
   olc_chan_if #(.payload_type(olc_pkg::rsp_type)) rsp_if ();
   olc_chan_if #(.payload_type(olc_pkg::csr_type)) csr_if ();

   occupancy_light_controller_top #(.AGE_WIDTH(AGE_W)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Items waiting to go in, and the light/motion results still owed by the block.
   olc_pkg::req_type tick_backlog[$];
   olc_pkg::rsp_type light_forecast[$];
   olc_pkg::rsp_type due_rsp;
   int unsigned items_queued = 0;
   int unsigned results_seen = 0;
   int unsigned mismatches   = 0;
   int unsigned cycle_count  = 0;
   bit          gaps_allowed = 1'b1;   // cleared for one whole phase: no idling there

   // Shadow of the controller: its registers and its state.
   olc_pkg::cfg_type shadow_cfg;
   logic             motion_flag;
   logic             light_state;
   logic [AGE_W-1:0] motion_age;
   logic [AGE_W-1:0] light_on_age;

   // Ages stick at all ones rather than wrap.
   function automatic logic [AGE_W-1:0] bump_age(input logic [AGE_W-1:0] age);
      return (&age) ? age : age + 1'b1;
   endfunction

   // Applies one item to the shadow state and returns the result it should produce.
   // A tick runs: motion update, hysteresis, light-on age, off-delay check.
   function automatic olc_pkg::rsp_type advance_light(input olc_pkg::req_type item);
      olc_pkg::rsp_type res;
      logic        was_lit;
      logic        was_moving;
      int unsigned upper;
      int unsigned lower;
      was_lit    = light_state;
      was_moving = motion_flag;
      if (item.cmd) begin
         // commands only count in manual mode; time does not move
         if (shadow_cfg.manual_override) light_state = item.manual_on;
      end else begin
         if (item.pir_level) begin
            motion_flag = 1'b1;
            motion_age  = '0;
         end else begin
            motion_age = bump_age(motion_age);
         end
         if (motion_age > shadow_cfg.motion_hold_ticks) motion_flag = 1'b0;
         // light-on age keeps counting in manual mode, restart only in automatic
         light_on_age = bump_age(light_on_age);
         if (!shadow_cfg.manual_override) begin
            if (motion_flag) begin
               upper = shadow_cfg.ambient_threshold + olc_pkg::AMB_BAND;
               // low edge of the band stops at zero
               lower = (shadow_cfg.ambient_threshold >= olc_pkg::AMB_BAND) ?
                       shadow_cfg.ambient_threshold - olc_pkg::AMB_BAND : 0;
               if (item.ambient_level > upper) light_state = 1'b0;
               else if (item.ambient_level < lower) light_state = 1'b1;
            end
            if (light_state && motion_flag) light_on_age = '0;
            if (light_state && light_on_age > shadow_cfg.off_delay_ticks) light_state = 1'b0;
         end
      end
      res.light_on       = light_state;
      res.light_changed  = light_state != was_lit;
      res.motion_recent  = motion_flag;
      res.motion_changed = motion_flag != was_moving;
      return res;
   endfunction

   function automatic void check_bit(input string field, input logic want, input logic got);
      if (want !== got) begin
         $error("%s: expected %0b, actual %0b", field, want, got);
         mismatches++;
      end
   endfunction

   // Request driver: next item from the backlog, ~8 % idle cycles when gaps are on.
   // The forecast is taken at the edge where the block accepts the item.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         motion_flag  = 1'b0;
         light_state  = 1'b0;
         motion_age   = '0;
         light_on_age = '0;
      end else begin
         if (req_if.valid && req_if.ready)
            light_forecast.push_back(advance_light(req_if.payload));
         if (!req_if.valid || req_if.ready) begin
            if (tick_backlog.size() != 0 && !(gaps_allowed && $urandom_range(99) < 8)) begin
               req_if.valid   <= 1'b1;
               req_if.payload <= tick_backlog.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: every accepted result is held against the oldest forecast.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (light_forecast.size() == 0) begin
               $error("result item with no item outstanding");
               mismatches++;
            end else begin
               due_rsp = light_forecast.pop_front();
               check_bit("light_on",       due_rsp.light_on,       rsp_if.payload.light_on);
               check_bit("light_changed",  due_rsp.light_changed,  rsp_if.payload.light_changed);
               check_bit("motion_recent",  due_rsp.motion_recent,  rsp_if.payload.motion_recent);
               check_bit("motion_changed", due_rsp.motion_changed, rsp_if.payload.motion_changed);
               results_seen++;
            end
         end
         rsp_if.ready <= !(gaps_allowed && $urandom_range(99) < 8);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // One register write; the shadow copy follows at the accepting edge.
   task automatic write_reg(input olc_pkg::csr_index_type idx,
                            input logic [olc_pkg::TICKS_W-1:0] value);
      olc_pkg::csr_type wr;
      wr.index = idx;
      wr.data  = value;
      @(posedge clock);
      csr_if.valid   <= 1'b1;
      csr_if.payload <= wr;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      unique case (idx)
         olc_pkg::CSR_MANUAL_OVERRIDE:
            shadow_cfg.manual_override   = value[0];
         olc_pkg::CSR_AMBIENT_THRESHOLD:
            shadow_cfg.ambient_threshold = value[olc_pkg::THRESH_W-1:0];
         olc_pkg::CSR_OFF_DELAY_TICKS:
            shadow_cfg.off_delay_ticks   = value;
         olc_pkg::CSR_MOTION_HOLD_TICKS:
            shadow_cfg.motion_hold_ticks = value;
      endcase
      csr_if.valid <= 1'b0;
   endtask

   // Wait until every queued item has its result back, then let the pipe settle.
   task automatic drain();
      while (results_seen != items_queued) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Registers change only with the block empty.
   task automatic set_phase(input logic ovr, input int unsigned thr,
                            input int unsigned off_dly, input int unsigned hold);
      drain();
      write_reg(olc_pkg::CSR_MANUAL_OVERRIDE, olc_pkg::TICKS_W'(ovr));
      write_reg(olc_pkg::CSR_AMBIENT_THRESHOLD, olc_pkg::TICKS_W'(thr));
      write_reg(olc_pkg::CSR_OFF_DELAY_TICKS, olc_pkg::TICKS_W'(off_dly));
      write_reg(olc_pkg::CSR_MOTION_HOLD_TICKS, olc_pkg::TICKS_W'(hold));
   endtask

   task automatic queue_item(input olc_pkg::req_type item);
      tick_backlog.push_back(item);
      items_queued++;
   endtask

   // Tick and command builders; the field the item does not use carries noise.
   task automatic queue_tick(input logic pir, input int unsigned amb);
      olc_pkg::req_type item;
      item.cmd           = 1'b0;
      item.pir_level     = pir;
      item.ambient_level = olc_pkg::AMBIENT_W'(amb);
      item.manual_on     = 1'($urandom_range(1));
      queue_item(item);
   endtask

   task automatic queue_command(input logic turn_on);
      olc_pkg::req_type item;
      item.cmd           = 1'b1;
      item.pir_level     = 1'($urandom_range(1));
      item.ambient_level = olc_pkg::AMBIENT_W'($urandom_range(4095));
      item.manual_on     = turn_on;
      queue_item(item);
   endtask

   // Ambient samples bunch around both band edges, where the hysteresis decides.
   task automatic queue_random_item();
      int thr;
      int amb;
      thr = int'(shadow_cfg.ambient_threshold);
      case ($urandom_range(3))
         0:       amb = $urandom_range(4095);
         1:       amb = thr - 100 + int'($urandom_range(4)) - 2;
         2:       amb = thr + 100 + int'($urandom_range(4)) - 2;
         default: amb = $urandom_range(1) ? 4095 : 0;
      endcase
      if (amb < 0) amb = 0;
      if (amb > 4095) amb = 4095;
      if ($urandom_range(99) < (shadow_cfg.manual_override ? 35 : 12))
         queue_command(1'($urandom_range(1)));
      else
         queue_tick($urandom_range(5) == 0, unsigned'(amb));
   endtask

   initial begin
      reset          <= 1'b1;
      csr_if.valid   <= 1'b0;
      csr_if.payload <= '0;
      shadow_cfg = '{1'b0, olc_pkg::THRESH_RESET, olc_pkg::OFF_DELAY_RESET,
                     olc_pkg::MOTION_HOLD_RESET};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults, automatic mode: band 1948..2148 around 2048.
      queue_command(1'b1);          // ignored in automatic mode
      queue_tick(1'b0, 0);          // dark, but no motion yet
      queue_tick(1'b1, 0);          // motion + dark: on
      queue_tick(1'b0, 2148);       // upper band edge: hold
      queue_tick(1'b0, 2149);       // above band: off
      queue_tick(1'b0, 1948);       // lower band edge: hold
      queue_tick(1'b0, 1947);       // below band: on
      queue_tick(1'b0, 4095);       // brightest: off

      // Threshold zero: low edge clamps at 0, light never turns on; motion hold of one tick.
      set_phase(1'b0, 0, 0, 1);
      queue_tick(1'b1, 0);
      queue_tick(1'b0, 100);
      queue_tick(1'b0, 101);        // hold runs out on this item too

      // Top threshold, zero hold: motion drops without PIR, off delay lets the light linger.
      set_phase(1'b0, 4096, 2, 0);
      queue_tick(1'b1, 3995);
      queue_tick(1'b0, 4095);
      queue_tick(1'b0, 0);
      queue_tick(1'b0, 0);          // age passes the off delay: off

      // Manual mode with longest hold: commands drive the light, ticks leave it alone.
      set_phase(1'b1, 2048, 0, 24'hFFFFFF);
      queue_command(1'b1);
      queue_tick(1'b1, 4095);
      queue_command(1'b0);
      queue_command(1'b0);          // no change
      queue_tick(1'b0, 0);

      // Random phases, extremes first, then random small delays so the ages expire often.
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0:       set_phase(1'b0, 0, 0, 0);
            1:       set_phase(1'b0, 4096, 24'hFFFFFF, 24'hFFFFFF);
            2:       set_phase(1'b0, 99, 3, 5);
            3:       set_phase(1'b0, 100, $urandom_range(40), $urandom_range(20));
            4:       set_phase(1'b1, $urandom_range(4096), 2, 3);
            default: set_phase($urandom_range(3) == 0, $urandom_range(4096),
                               $urandom_range(40), $urandom_range(25));
         endcase
         gaps_allowed = (phase != 3);
         repeat (65) queue_random_item();
      end

      drain();
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
